@@ rtl/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, constants and helpers for the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Digits in one code; a code is held as BCD, first digit in the top nibble.
    localparam int CODE_DIGITS = 4;
    localparam int CODE_W      = 4 * CODE_DIGITS;

    localparam int KEY_W = 4;
    localparam int EV_W  = 3;
    localparam int CNT_W = 3;
    localparam int CFG_W = 16;

    // Count value at which the next digit completes a code.
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS - 1);

    localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_ADMIN      = 4'd10;
    localparam logic [KEY_W-1:0] KEY_CLEAR      = 4'd12;

    localparam logic [CFG_W-1:0] USER_CODE_RST = 16'h1234;

    typedef enum logic [EV_W-1:0] {
        EV_DIGIT    = 3'd0,
        EV_GRANTED  = 3'd1,
        EV_WRONG    = 3'd2,
        EV_APROMPT  = 3'd3,
        EV_ADMINOK  = 3'd4,
        EV_NEWDIGIT = 3'd5,
        EV_CHANGED  = 3'd6,
        EV_CLEARED  = 3'd7
    } event_t;

    // Lock state carried from one key to the next.
    typedef struct packed {
        logic [CODE_W-1:0] user_code;
        logic [CODE_W-1:0] entry_digits;
        logic [CNT_W-1:0]  entry_count;
        logic              admin_mode;
        logic              new_code_phase;
    } lock_state_t;

    // One key's outcome towards the result register.
    typedef struct packed {
        logic             has_res;
        event_t           ev;
        logic             admin_active;
        logic [CNT_W-1:0] digits_held;
    } step_res_t;

    // 16-bit BCD word fitted to the code width (zero-extend or truncate).
    function automatic logic [CODE_W-1:0] fit_code(input logic [CFG_W-1:0] val);
        logic [CODE_W+CFG_W-1:0] ext;
        begin
            ext = {{CODE_W{1'b0}}, val};
            return ext[CODE_W-1:0];
        end
    endfunction

endpackage

@@ rtl/kcl_step.sv @@
// ----------------------------------------------------------------------------
// kcl_step
// Next-state and event decode for one key press.
// ----------------------------------------------------------------------------
module kcl_step
(
    input  logic [kcl_pkg::KEY_W-1:0]  key,
    input  kcl_pkg::lock_state_t       cur,
    input  logic [kcl_pkg::CODE_W-1:0] admin_cmp,
    output kcl_pkg::lock_state_t       nxt,
    output kcl_pkg::step_res_t         res
);

    logic                       is_digit;
    logic                       last_digit;
    logic [kcl_pkg::CODE_W-1:0] shifted;

    assign is_digit   = (key <= kcl_pkg::KEY_LAST_DIGIT);
    assign last_digit = (cur.entry_count == kcl_pkg::CNT_LAST);
    assign shifted    = (cur.entry_digits << 4) | kcl_pkg::CODE_W'(key);

    always_comb
    begin
        nxt         = cur;
        res.has_res = 1'b0;
        res.ev      = kcl_pkg::EV_DIGIT;

        if (is_digit)
        begin
            nxt.entry_digits = shifted;
            res.has_res      = 1'b1;
            if (!last_digit)
            begin
                nxt.entry_count = cur.entry_count + 1'b1;
                res.ev = cur.new_code_phase ? kcl_pkg::EV_NEWDIGIT : kcl_pkg::EV_DIGIT;
            end
            else
            begin
                nxt.entry_count = '0;
                priority if (cur.new_code_phase)
                begin
                    nxt.user_code      = shifted;
                    nxt.new_code_phase = 1'b0;
                    nxt.admin_mode     = 1'b0;
                    res.ev             = kcl_pkg::EV_CHANGED;
                end
                else if (!cur.admin_mode)
                begin
                    res.ev = (shifted == cur.user_code) ? kcl_pkg::EV_GRANTED
                                                        : kcl_pkg::EV_WRONG;
                end
                else if (shifted == admin_cmp)
                begin
                    nxt.new_code_phase = 1'b1;
                    res.ev             = kcl_pkg::EV_ADMINOK;
                end
                else
                begin
                    res.ev = kcl_pkg::EV_WRONG;
                end
            end
        end
        else if (!cur.new_code_phase)
        begin
            // non-digit keys are dead while a new code is being keyed
            if (key == kcl_pkg::KEY_ADMIN)
            begin
                nxt.admin_mode  = 1'b1;
                nxt.entry_count = '0;
                res.has_res     = 1'b1;
                res.ev          = kcl_pkg::EV_APROMPT;
            end
            else if (key == kcl_pkg::KEY_CLEAR)
            begin
                nxt.entry_count = '0;
                res.has_res     = 1'b1;
                res.ev          = kcl_pkg::EV_CLEARED;
            end
        end

        res.admin_active = nxt.admin_mode;
        res.digits_held  = nxt.entry_count;
    end

endmodule

@@ rtl/kcl_out_stage.sv @@
// ----------------------------------------------------------------------------
// kcl_out_stage
// Result register with valid/stall handshake.
// ----------------------------------------------------------------------------
module kcl_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  kcl_pkg::step_res_t             res,
    output logic                           can_load,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kcl_pkg::EV_W-1:0]       event_res,
    output logic                           admin_active,
    output logic [kcl_pkg::CNT_W-1:0]      digits_held
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [kcl_pkg::EV_W-1:0]     ev_reg;
    logic                         admin_reg;
    logic [kcl_pkg::CNT_W-1:0]    held_reg;

    // free when empty or being drained this cycle
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg    <= res.ev;
            admin_reg <= res.admin_active;
            held_reg  <= res.digits_held;
        end
    end

    assign out_valid    = valid_reg;
    assign event_res    = ev_reg;
    assign admin_active = admin_reg;
    assign digits_held  = held_reg;

endmodule

@@ rtl/keypad_code_lock_fsm.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock_fsm
// Keypad code lock with user access check and admin-driven code change.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  in       | in_valid / in_stall        | key_code
//  out      | out_valid / out_stall      | event_res, admin_active, digits_held
//  config   | admin_code_we (no wait)    | admin_code
//
//  One key request per cycle while out_stall is low; an accepted request passes
//  through the input register, then the result register.
//  B, D, star and hash, and non-digit keys during new-code entry, update
//  nothing and yield no result request.
//  Reset: user code 1234, admin code 0, buffer and count empty, flags clear.
//  A stalled result holds; the input register still takes one more request,
//  after which in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module keypad_code_lock_fsm
(
    input  logic                           clk,
    input  logic                           rst_n,
    // key requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [kcl_pkg::KEY_W-1:0]      key_code,
    // results
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kcl_pkg::EV_W-1:0]       event_res,
    output logic                           admin_active,
    output logic [kcl_pkg::CNT_W-1:0]      digits_held,
    // admin code register
    input  logic                           admin_code_we,
    input  logic [kcl_pkg::CFG_W-1:0]      admin_code
);

    // input register
    logic                         key_valid_reg;
    logic                         key_valid_next;
    logic [kcl_pkg::KEY_W-1:0]    key_reg;

    // lock state and admin code
    kcl_pkg::lock_state_t         state_reg;
    kcl_pkg::lock_state_t         state_next;
    logic [kcl_pkg::CFG_W-1:0]    admin_code_reg;

    kcl_pkg::step_res_t           step_res;
    logic                         out_free;
    logic                         advance;
    logic                         in_take;

    // the held key is consumed once the result register can take its outcome
    assign advance  = key_valid_reg && out_free;
    assign in_stall = key_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        key_valid_next = key_valid_reg;
        if (in_take)
            key_valid_next = 1'b1;
        else if (advance)
            key_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_valid_reg <= 1'b0;
        else
            key_valid_reg <= key_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            key_reg <= key_code;
    end

    // admin code: to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            admin_code_reg <= '0;
        else if (admin_code_we)
            admin_code_reg <= admin_code;
    end

    kcl_step u_step
    (
        .key       (key_reg),
        .cur       (state_reg),
        .admin_cmp (kcl_pkg::fit_code(admin_code_reg)),
        .nxt       (state_next),
        .res       (step_res)
    );

    // state moves only when a key is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.user_code      <= kcl_pkg::fit_code(kcl_pkg::USER_CODE_RST);
            state_reg.entry_digits   <= '0;
            state_reg.entry_count    <= '0;
            state_reg.admin_mode     <= 1'b0;
            state_reg.new_code_phase <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    kcl_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && step_res.has_res),
        .res          (step_res),
        .can_load     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .admin_active (admin_active),
        .digits_held  (digits_held)
    );

endmodule

@@ rtl/kcl_checker.sv @@
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks on the keypad code lock, bound to the top level.
// ----------------------------------------------------------------------------
module kcl_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [kcl_pkg::EV_W-1:0]  event_res,
    input  logic                      admin_active,
    input  logic [kcl_pkg::CNT_W-1:0] digits_held
);

    // a stalled result stays up and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res)
                                   && $stable(admin_active) && $stable(digits_held))
        else $error("stalled result changed");

    // any check, prompt or clear leaves the buffer empty
    a_empty_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == kcl_pkg::EV_GRANTED || event_res == kcl_pkg::EV_WRONG
                      || event_res == kcl_pkg::EV_APROMPT
                      || event_res == kcl_pkg::EV_ADMINOK
                      || event_res == kcl_pkg::EV_CHANGED
                      || event_res == kcl_pkg::EV_CLEARED)
        |-> digits_held == '0)
        else $error("buffer not empty after check");

    // admin flag follows the admin events
    a_admin_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res != kcl_pkg::EV_CHANGED || !admin_active)
                      && (!(event_res == kcl_pkg::EV_APROMPT
                            || event_res == kcl_pkg::EV_ADMINOK
                            || event_res == kcl_pkg::EV_NEWDIGIT) || admin_active))
        else $error("admin flag inconsistent with event");

    // a digit that does not complete a code leaves 1..CODE_DIGITS-1 held
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == kcl_pkg::EV_DIGIT || event_res == kcl_pkg::EV_NEWDIGIT)
        |-> digits_held != '0 && digits_held <= kcl_pkg::CNT_LAST)
        else $error("digit count out of range");

endmodule

bind keypad_code_lock_fsm kcl_checker u_kcl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .admin_active (admin_active),
    .digits_held  (digits_held)
);

@@ tb/sv/keypad_code_lock_fsm_test.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock_fsm_test
// Self-checking bench for the keypad code lock: a short scripted key run,
// then random key sequences under several admin codes, with random idling on
// both channels and a long result hold-off. Every result request is checked
// against an in-bench model of the lock, or for a typed script row against the row.
// ----------------------------------------------------------------------------
module keypad_code_lock_fsm_test;

    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    // Keys with no effect at all; the admin and clear keys come from the package.
    localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
    localparam logic [KEY_W-1:0] KEY_D    = 4'd13;
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

    // Two register stages from key to result; a few spare cycles on top.
    localparam int DRAIN_CYCLES = 6;
    // Run limit in nanoseconds, set with a wide margin over the expected run.
    localparam int LIMIT_NS     = 5_000_000;
    localparam int PHASE_EVENTS = 95;
    localparam int HOLD_CYCLES  = 40;

    // One result request as the lock should report it.
    typedef struct packed {
        event_t           ev;
        logic             admin;
        logic [CNT_W-1:0] held;
    } lock_res_t;

    // One row of the scripted run. Where typed is set, the outcome in the
    // row is the one to see (has_res clear means no result at all).
    typedef struct packed {
        logic [KEY_W-1:0] key;
        bit               typed;
        bit               has_res;
        event_t           ev;
        logic             admin;
        logic [CNT_W-1:0] held;
    } key_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [KEY_W-1:0] key_code;
    logic             out_valid;
    logic             out_stall;
    logic [EV_W-1:0]  event_res;
    logic             admin_active;
    logic [CNT_W-1:0] digits_held;
    logic             admin_code_we;
    logic [CFG_W-1:0] admin_code;

    keypad_code_lock_fsm dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_code     (key_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .admin_active (admin_active),
        .digits_held  (digits_held),
        .admin_code_we(admin_code_we),
        .admin_code   (admin_code)
    );

    // Model copy of the lock state and of the admin code register.
    logic [CODE_W-1:0] lock_user_code;
    logic [CODE_W-1:0] lock_entry;
    int                lock_count;
    logic              lock_admin;
    logic              lock_newcode;
    logic [CFG_W-1:0]  cfg_admin;

    lock_res_t pending_events[$];

    int  mismatches    = 0;
    int  keys_sent     = 0;
    int  ignored_keys  = 0;
    int  events_queued = 0;
    int  events_seen   = 0;
    int  grants_seen   = 0;
    int  changes_seen  = 0;
    int  cfg_writes    = 0;
    int  hold_left     = 0;   // set by the stimulus, counted down by the receiver
    bit  quiet         = 1'b0; // no idling on either side while set, but for a counted hold-off

    // Scripted run with the admin code at zero. Covers: the field extremes,
    // a grant on the reset user code, ignored keys, clear, the admin key
    // pressed again mid-entry, admin and clear ignored during new-code entry,
    // a code change to all nines, and a wrong user code after it.
    key_row_t script [25] = '{
        '{4'd1,      1'b1, 1'b1, EV_DIGIT,    1'b0, 3'd1},
        '{4'd2,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd3,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd4,      1'b1, 1'b1, EV_GRANTED,  1'b0, 3'd0},
        '{KEY_HASH,  1'b1, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{KEY_B,     1'b1, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd9,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{KEY_CLEAR, 1'b1, 1'b1, EV_CLEARED,  1'b0, 3'd0},
        '{KEY_ADMIN, 1'b1, 1'b1, EV_APROMPT,  1'b1, 3'd0},
        '{4'd5,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{KEY_ADMIN, 1'b1, 1'b1, EV_APROMPT,  1'b1, 3'd0},
        '{4'd0,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd0,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd0,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd0,      1'b1, 1'b1, EV_ADMINOK,  1'b1, 3'd0},
        '{KEY_ADMIN, 1'b1, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{KEY_CLEAR, 1'b1, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd9,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd9,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd9,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd9,      1'b1, 1'b1, EV_CHANGED,  1'b0, 3'd0},
        '{4'd9,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd9,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd9,      1'b0, 1'b0, EV_DIGIT,    1'b0, 3'd0},
        '{4'd8,      1'b1, 1'b1, EV_WRONG,    1'b0, 3'd0}
    };

    // ------------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int rand_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_ignored();
        begin
            case ($urandom_range(0, 3))
                0:       return KEY_B;
                1:       return KEY_D;
                2:       return KEY_STAR;
                default: return KEY_HASH;
            endcase
        end
    endfunction

    // Digit i of a code, first digit in the top nibble.
    function automatic logic [KEY_W-1:0] code_digit(input logic [CODE_W-1:0] code,
                                                    input int i);
        begin
            return code[(CODE_W - 1 - 4 * i) -: 4];
        end
    endfunction

    // ------------------------------------------------------------------------
    // Lock model: applies one accepted key and gives the result it causes.
    // ------------------------------------------------------------------------
    task automatic lock_predict(input logic [KEY_W-1:0] key, output bit got,
                                output lock_res_t res);
        event_t ev;
        begin
            got = 1'b0;
            ev  = EV_DIGIT;
            if (key <= KEY_LAST_DIGIT)
            begin
                lock_entry = (lock_entry << 4) | CODE_W'(key);
                lock_count = lock_count + 1;
                got = 1'b1;
                if (lock_count < CODE_DIGITS)
                    ev = lock_newcode ? EV_NEWDIGIT : EV_DIGIT;
                else
                begin
                    // Full code held: the check depends on the phase and mode.
                    lock_count = 0;
                    if (lock_newcode)
                    begin
                        lock_user_code = lock_entry;
                        lock_newcode   = 1'b0;
                        lock_admin     = 1'b0;
                        ev             = EV_CHANGED;
                    end
                    else if (!lock_admin)
                        ev = (lock_entry == lock_user_code) ? EV_GRANTED : EV_WRONG;
                    else if (lock_entry == CODE_W'(cfg_admin))
                    begin
                        lock_newcode = 1'b1;
                        ev           = EV_ADMINOK;
                    end
                    else
                        ev = EV_WRONG;   // admin mode stays set
                end
            end
            else if (!lock_newcode)
            begin
                // During new-code entry only digits count.
                if (key == KEY_ADMIN)
                begin
                    lock_admin = 1'b1;
                    lock_count = 0;
                    ev         = EV_APROMPT;
                    got        = 1'b1;
                end
                else if (key == KEY_CLEAR)
                begin
                    lock_count = 0;
                    ev         = EV_CLEARED;
                    got        = 1'b1;
                end
            end
            res = '{ev, lock_admin, CNT_W'(lock_count)};
        end
    endtask

    // ------------------------------------------------------------------------
    // Key sender: idles for a while, offers the key, holds it until taken,
    // then files the expected result (typed one for a typed script row).
    // ------------------------------------------------------------------------
    task automatic press_key(input key_row_t row);
        int        gap;
        bit        got;
        lock_res_t res;
        begin
            gap = quiet ? 0 : rand_gap();
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                key_code <= KEY_W'($urandom);
            end
            @(negedge clk);
            in_valid <= 1'b1;
            key_code <= row.key;
            // in_stall read here is the value before the edge
            do
                @(posedge clk);
            while (in_stall);
            lock_predict(row.key, got, res);
            if (row.typed)
            begin
                got = row.has_res;
                res = '{row.ev, row.admin, row.held};
            end
            keys_sent++;
            if (got)
            begin
                pending_events.push_back(res);
                events_queued++;
            end
            else
                ignored_keys++;
        end
    endtask

    task automatic tap(input logic [KEY_W-1:0] k);
        key_row_t row;
        begin
            row     = '0;
            row.key = k;
            press_key(row);
        end
    endtask

    task automatic idle_input();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Wait for every outstanding result, then for the pipe to settle.
    task automatic wait_drained();
        begin
            while (pending_events.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES)
                @(posedge clk);
        end
    endtask

    // Register write, only with the lock idle.
    task automatic write_admin_code(input logic [CFG_W-1:0] val);
        begin
            idle_input();
            wait_drained();
            @(negedge clk);
            admin_code_we <= 1'b1;
            admin_code    <= val;
            @(posedge clk);
            cfg_admin = val;
            cfg_writes++;
            @(negedge clk);
            admin_code_we <= 1'b0;
        end
    endtask

    function automatic logic [CFG_W-1:0] rand_bcd();
        logic [CFG_W-1:0] v;
        begin
            v = '0;
            for (int i = 0; i < 4; i++)
                v = (v << 4) | CFG_W'($urandom_range(0, 9));
            return v;
        end
    endfunction

    // ------------------------------------------------------------------------
    // One random key sequence. Mostly well-formed entries: the current user code,
    // random codes, admin logins followed by a new code; the rest is broken
    // entries, cleared entries and raw noise.
    // ------------------------------------------------------------------------
    task automatic key_sequence();
        int kind;
        int n;
        begin
            kind = $urandom_range(0, 99);
            // most sequences start from an empty buffer
            if (lock_count != 0 && !lock_newcode && $urandom_range(0, 4) != 0)
                tap(KEY_CLEAR);
            if (kind < 30)
            begin
                for (int i = 0; i < CODE_DIGITS; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        tap(pick_ignored());
                    tap(code_digit(lock_user_code, i));
                end
            end
            else if (kind < 45)
            begin
                for (int i = 0; i < CODE_DIGITS; i++)
                    tap(KEY_W'($urandom_range(0, 9)));
            end
            else if (kind < 70)
            begin
                tap(KEY_ADMIN);
                for (int i = 0; i < CODE_DIGITS; i++)
                    tap(code_digit(CODE_W'(cfg_admin), i));
                // new code, with stray non-digits that must be ignored
                for (int i = 0; i < CODE_DIGITS; i++)
                begin
                    if ($urandom_range(0, 6) == 0)
                        tap(KEY_W'($urandom_range(10, 15)));
                    tap(KEY_W'($urandom_range(0, 9)));
                end
            end
            else if (kind < 80)
            begin
                tap(KEY_ADMIN);
                n = $urandom_range(0, CODE_DIGITS);
                for (int i = 0; i < n; i++)
                    tap(KEY_W'($urandom_range(0, 9)));
                case ($urandom_range(0, 2))
                    0:       tap(KEY_ADMIN);
                    1:       tap(KEY_CLEAR);
                    default: ;
                endcase
            end
            else if (kind < 90)
            begin
                n = $urandom_range(1, CODE_DIGITS - 1);
                for (int i = 0; i < n; i++)
                    tap(KEY_W'($urandom_range(0, 9)));
                tap(KEY_CLEAR);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    tap(KEY_W'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic random_phase(input int n_events);
        int start;
        begin
            start = events_queued;
            while (events_queued - start < n_events)
                key_sequence();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random stall pattern, a counted hold-off on request,
    // and no random stalls in quiet stretches.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int pass_left;
        stall_left = 0;
        pass_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (pass_left > 0)
            begin
                out_stall <= 1'b0;
                pass_left--;
            end
            else
            begin
                stall_left = rand_gap();
                pass_left  = $urandom_range(1, 12);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each taken result against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lock_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            events_seen++;
            if (pending_events.size() == 0)
            begin
                $display("%0t: result with nothing expected: event %0d admin %0d held %0d",
                         $time, event_res, admin_active, digits_held);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (want.ev == EV_GRANTED)
                    grants_seen++;
                if (want.ev == EV_CHANGED)
                    changes_seen++;
                if (event_res != want.ev)
                begin
                    $display("%0t: event_res expected %0d actual %0d",
                             $time, want.ev, event_res);
                    mismatches++;
                end
                if (admin_active != want.admin)
                begin
                    $display("%0t: admin_active expected %0d actual %0d",
                             $time, want.admin, admin_active);
                    mismatches++;
                end
                if (digits_held != want.held)
                begin
                    $display("%0t: digits_held expected %0d actual %0d",
                             $time, want.held, digits_held);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------------
    initial
    begin
        #(LIMIT_NS);
        $display("%0t: run limit reached, %0d results outstanding",
                 $time, pending_events.size());
        $display("keypad_code_lock_fsm: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] phase_code [5];

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        key_code      = '0;
        admin_code_we = 1'b0;
        admin_code    = '0;

        lock_user_code = CODE_W'(USER_CODE_RST);
        lock_entry     = '0;
        lock_count     = 0;
        lock_admin     = 1'b0;
        lock_newcode   = 1'b0;
        cfg_admin      = '0;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Scripted run expects an admin code of zero.
        write_admin_code(16'h0000);
        foreach (script[i])
            press_key(script[i]);

        // Long result hold-off while keys keep coming back to back: the
        // result register and the input register fill and in_stall rises.
        write_admin_code(16'h9999);
        quiet     = 1'b1;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
            tap(KEY_W'($urandom_range(0, 9)));
        quiet = 1'b0;
        // sender waits for every outstanding result before going on
        idle_input();
        wait_drained();

        // Admin code per random phase: top extreme, random BCD, zero with no
        // idling at all, random BCD, and a raw value that may not be BCD.
        phase_code[0] = 16'h9999;
        phase_code[1] = rand_bcd();
        phase_code[2] = 16'h0000;
        phase_code[3] = rand_bcd();
        phase_code[4] = CFG_W'($urandom_range(0, 39321));
        for (int p = 0; p < 5; p++)
        begin
            if (p != 0)
                write_admin_code(phase_code[p]);
            quiet = (p == 2);
            random_phase(PHASE_EVENTS);
            quiet = 1'b0;
        end

        idle_input();
        wait_drained();

        $display("Run covered %0d key requests (%0d ignored) and %0d results checked,",
                 keys_sent, ignored_keys, events_seen);
        $display("with %0d grants, %0d code changes and %0d admin code writes.",
                 grants_seen, changes_seen, cfg_writes);
        if (mismatches == 0)
            $display("keypad_code_lock_fsm: match");
        else
            $display("keypad_code_lock_fsm: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kcl_pkg.sv
rtl/kcl_step.sv
rtl/kcl_out_stage.sv
rtl/keypad_code_lock_fsm.sv
rtl/kcl_checker.sv
tb/sv/keypad_code_lock_fsm_test.sv
